// ===== src/dfhe_pkg.sv =====
`timescale 1ns / 1ps

package dfhe_pkg;

    localparam int TOK_W  = 31;   // longest token: 8 + 5 + 5 + 13 bits
    localparam int BUF_W  = 40;   // five output bytes
    localparam int ACC_W  = 48;

    localparam logic [1:0] CMD_LITERAL = 2'd0;
    localparam logic [1:0] CMD_MATCH   = 2'd1;
    localparam logic [1:0] CMD_END     = 2'd2;
    localparam logic [1:0] CMD_UNUSED  = 2'd3;

    localparam logic [8:0] SYM_END      = 9'd256;
    localparam logic [8:0] SYM_LEN_BASE = 9'd257;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  literal_value;
        logic [8:0]  match_length;
        logic [15:0] match_distance;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } out_t;

    // token bit string, first bit in bit 0
    typedef struct packed {
        logic             is_end;
        logic [4:0]       nbits;
        logic [TOK_W-1:0] bits;
    } tok_t;

    function automatic logic [8:0] len_base(input logic [4:0] idx);
        case (idx)
            5'd0:    return 9'd3;
            5'd1:    return 9'd4;
            5'd2:    return 9'd5;
            5'd3:    return 9'd6;
            5'd4:    return 9'd7;
            5'd5:    return 9'd8;
            5'd6:    return 9'd9;
            5'd7:    return 9'd10;
            5'd8:    return 9'd11;
            5'd9:    return 9'd13;
            5'd10:   return 9'd15;
            5'd11:   return 9'd17;
            5'd12:   return 9'd19;
            5'd13:   return 9'd23;
            5'd14:   return 9'd27;
            5'd15:   return 9'd31;
            5'd16:   return 9'd35;
            5'd17:   return 9'd43;
            5'd18:   return 9'd51;
            5'd19:   return 9'd59;
            5'd20:   return 9'd67;
            5'd21:   return 9'd83;
            5'd22:   return 9'd99;
            5'd23:   return 9'd115;
            5'd24:   return 9'd131;
            5'd25:   return 9'd163;
            5'd26:   return 9'd195;
            5'd27:   return 9'd227;
            5'd28:   return 9'd258;
            default: return 9'd258;
        endcase
    endfunction

    function automatic logic [2:0] len_extra(input logic [4:0] idx);
        if (idx < 5'd8 || idx == 5'd28) return 3'd0;
        else return 3'(((idx - 5'd8) >> 2) + 5'd1);
    endfunction

    function automatic logic [15:0] dist_base(input logic [4:0] idx);
        case (idx)
            5'd0:    return 16'd1;
            5'd1:    return 16'd2;
            5'd2:    return 16'd3;
            5'd3:    return 16'd4;
            5'd4:    return 16'd5;
            5'd5:    return 16'd7;
            5'd6:    return 16'd9;
            5'd7:    return 16'd13;
            5'd8:    return 16'd17;
            5'd9:    return 16'd25;
            5'd10:   return 16'd33;
            5'd11:   return 16'd49;
            5'd12:   return 16'd65;
            5'd13:   return 16'd97;
            5'd14:   return 16'd129;
            5'd15:   return 16'd193;
            5'd16:   return 16'd257;
            5'd17:   return 16'd385;
            5'd18:   return 16'd513;
            5'd19:   return 16'd769;
            5'd20:   return 16'd1025;
            5'd21:   return 16'd1537;
            5'd22:   return 16'd2049;
            5'd23:   return 16'd3073;
            5'd24:   return 16'd4097;
            5'd25:   return 16'd6145;
            5'd26:   return 16'd8193;
            5'd27:   return 16'd12289;
            5'd28:   return 16'd16385;
            5'd29:   return 16'd24577;
            default: return 16'd24577;
        endcase
    endfunction

    function automatic logic [3:0] dist_extra(input logic [4:0] idx);
        if (idx < 5'd4) return 4'd0;
        else return 4'((idx - 5'd2) >> 1);
    endfunction

    // fixed literal/length code: {length, code}, code sent MSB first
    function automatic logic [12:0] sym_code(input logic [8:0] s);
        if (s < 9'd144)      return {4'd8, 9'h030 + s};
        else if (s < 9'd256) return {4'd9, 9'h190 + (s - 9'd144)};
        else if (s < 9'd280) return {4'd7, s - 9'd256};
        else                 return {4'd8, 9'h0C0 + (s - 9'd280)};
    endfunction

endpackage

// ===== src/dfhe_encode.sv =====
`timescale 1ns / 1ps

module dfhe_encode
    import dfhe_pkg::*;
(
    input  in_t  tok_in,
    output tok_t tok_out
);

    logic [8:0]       len;
    logic [15:0]      dist_val;
    logic [4:0]       li;
    logic [4:0]       dc;
    logic [8:0]       sym;
    logic [12:0]      sc;
    logic [3:0]       sym_n;
    logic [8:0]       aligned;
    logic [8:0]       sym_rev;
    logic [4:0]       dc_rev;
    logic [4:0]       lext;
    logic [2:0]       lext_n;
    logic [15:0]      dext_full;
    logic [12:0]      dext;
    logic [3:0]       dext_n;
    logic [4:0]       pos;
    logic [TOK_W-1:0] bits;

    always_comb
    begin
        len = tok_in.match_length;
        if (len < 9'd3)
        begin
            len = 9'd3;
        end
        else if (len > 9'd258)
        begin
            len = 9'd258;
        end
        dist_val = tok_in.match_distance;
        if (dist_val == 16'd0)
        begin
            dist_val = 16'd1;
        end

        // largest table entry not above the value
        li = 5'd0;
        for (int k = 1; k < 29; k++)
        begin
            if (len >= len_base(5'(k)))
            begin
                li = 5'(k);
            end
        end
        dc = 5'd0;
        for (int k = 1; k < 30; k++)
        begin
            if (dist_val >= dist_base(5'(k)))
            begin
                dc = 5'(k);
            end
        end

        case (tok_in.cmd)
            CMD_LITERAL: sym = {1'b0, tok_in.literal_value};
            CMD_MATCH:   sym = SYM_LEN_BASE + 9'(li);
            default:     sym = SYM_END;
        endcase

        sc      = sym_code(sym);
        sym_n   = sc[12:9];
        // left-align then mirror so the MSB goes out first
        aligned = sc[8:0] << (4'd9 - sym_n);
        for (int k = 0; k < 9; k++)
        begin
            sym_rev[k] = aligned[8-k];
        end
        for (int k = 0; k < 5; k++)
        begin
            dc_rev[k] = dc[4-k];
        end

        lext      = 5'(len - len_base(li));
        lext_n    = len_extra(li);
        dext_full = dist_val - dist_base(dc);
        dext_n    = dist_extra(dc);
        dext      = dext_full[12:0] & ((13'd1 << dext_n) - 13'd1);

        bits = TOK_W'(sym_rev);
        pos  = 5'(sym_n);
        if (tok_in.cmd == CMD_MATCH)
        begin
            bits = bits | (TOK_W'(lext) << pos);
            pos  = pos + 5'(lext_n);
            bits = bits | (TOK_W'(dc_rev) << pos);
            pos  = pos + 5'd5;
            bits = bits | (TOK_W'(dext) << pos);
            pos  = pos + 5'(dext_n);
        end

        tok_out.is_end = (tok_in.cmd == CMD_END);
        tok_out.nbits  = pos;
        tok_out.bits   = bits;
    end

endmodule

// ===== src/deflate_fixed_huffman_token_encoder.sv =====
`timescale 1ns / 1ps

// Fixed-Huffman DEFLATE token encoder.
// Input channel (in_valid/in_ready/in_data): one LZ77 token per request,
// literal, match or end of block; command code 3 is taken and dropped.
// Output channel (out_valid/out_ready/out_data): packed DEFLATE bytes, bit
// 0 first; last_of_run marks the final byte a token produced.
// cfg_we/cfg_wdata set the BFINAL bit, sampled when a block header goes out.
// Pipeline: input register, token code register, byte buffer of five bytes.
// A token's bytes pass the input and token code registers, then the buffer.
// While out_ready is high a token is taken every cycle if tokens complete at
// most one byte each; a token yielding more (up to 5 bytes for a long match)
// holds the buffer, which drains one byte per cycle and so sets the rate.
// When out_ready is low the buffer holds, and the two registers ahead of it
// fill before in_ready drops.
// Reset empties the pipeline, clears pending bits and the header flag, and
// sets BFINAL to 1.
module deflate_fixed_huffman_token_encoder
    import dfhe_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data,
    input  logic cfg_we,
    input  logic cfg_wdata
);

    in_t              a_data_reg;
    logic             a_valid_reg, a_valid_next;
    tok_t             tok_reg;
    tok_t             tok_enc;
    logic             tok_valid_reg, tok_valid_next;
    logic [BUF_W-1:0] buf_reg, buf_next;
    logic [2:0]       buf_cnt_reg, buf_cnt_next;
    logic [6:0]       pend_bits_reg, pend_bits_next;
    logic [2:0]       pend_cnt_reg, pend_cnt_next;
    logic             hdr_done_reg, hdr_done_next;
    logic             final_block_reg;

    logic             in_acc, out_acc;
    logic             c_load, tok_take, a_move;
    logic [ACC_W-1:0] acc;
    logic [3:0]       tok_sh;
    logic [5:0]       nbits_total;
    logic [2:0]       full_bytes;
    logic [2:0]       load_cnt;

    dfhe_encode u_encode (
        .tok_in  (a_data_reg),
        .tok_out (tok_enc)
    );

    assign out_valid = (buf_cnt_reg != 3'd0);
    assign out_acc   = out_valid && out_ready;
    assign c_load    = tok_valid_reg
                       && ((buf_cnt_reg == 3'd0) || ((buf_cnt_reg == 3'd1) && out_ready));
    assign tok_take  = !tok_valid_reg || c_load;
    assign a_move    = a_valid_reg && tok_take;
    assign in_ready  = !a_valid_reg || tok_take;
    assign in_acc    = in_valid && in_ready;

    assign out_data.out_byte    = buf_reg[7:0];
    assign out_data.last_of_run = (buf_cnt_reg == 3'd1);

    // join pending bits, block header and token bits
    always_comb
    begin
        acc    = ACC_W'(pend_bits_reg);
        tok_sh = 4'(pend_cnt_reg);
        if (!hdr_done_reg)
        begin
            acc    = acc | (ACC_W'({2'b01, final_block_reg}) << pend_cnt_reg);
            tok_sh = tok_sh + 4'd3;
        end
        acc         = acc | (ACC_W'(tok_reg.bits) << tok_sh);
        nbits_total = 6'(tok_sh) + 6'(tok_reg.nbits);
        full_bytes  = nbits_total[5:3];
        load_cnt    = full_bytes;
        if (tok_reg.is_end && (nbits_total[2:0] != 3'd0))
        begin
            load_cnt = full_bytes + 3'd1;   // zero-padded final byte
        end
    end

    always_comb
    begin
        a_valid_next   = a_valid_reg;
        tok_valid_next = tok_valid_reg;
        buf_next       = buf_reg;
        buf_cnt_next   = buf_cnt_reg;
        pend_bits_next = pend_bits_reg;
        pend_cnt_next  = pend_cnt_reg;
        hdr_done_next  = hdr_done_reg;

        if (a_move)
        begin
            a_valid_next = 1'b0;
        end
        if (in_acc)
        begin
            a_valid_next = (in_data.cmd != CMD_UNUSED);
        end

        if (c_load)
        begin
            tok_valid_next = 1'b0;
        end
        if (a_move)
        begin
            tok_valid_next = 1'b1;
        end

        if (c_load)
        begin
            buf_next     = acc[BUF_W-1:0];
            buf_cnt_next = load_cnt;
            if (tok_reg.is_end)
            begin
                pend_bits_next = 7'd0;
                pend_cnt_next  = 3'd0;
                hdr_done_next  = 1'b0;
            end
            else
            begin
                pend_bits_next = 7'(acc >> {full_bytes, 3'b000});
                pend_cnt_next  = nbits_total[2:0];
                hdr_done_next  = 1'b1;
            end
        end
        else if (out_acc)
        begin
            buf_next     = buf_reg >> 8;
            buf_cnt_next = buf_cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg     <= 1'b0;
            tok_valid_reg   <= 1'b0;
            buf_cnt_reg     <= 3'd0;
            pend_bits_reg   <= 7'd0;
            pend_cnt_reg    <= 3'd0;
            hdr_done_reg    <= 1'b0;
            final_block_reg <= 1'b1;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            tok_valid_reg <= tok_valid_next;
            buf_cnt_reg   <= buf_cnt_next;
            pend_bits_reg <= pend_bits_next;
            pend_cnt_reg  <= pend_cnt_next;
            hdr_done_reg  <= hdr_done_next;
            if (cfg_we)
            begin
                final_block_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            a_data_reg <= in_data;
        end
        if (a_move)
        begin
            tok_reg <= tok_enc;
        end
        buf_reg <= buf_next;
    end

`ifndef NO_ASSERTIONS
    a_buf_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
        buf_cnt_reg <= 3'd5)
        else $error("byte buffer count above five");

    a_no_reload_busy: assert property (@(posedge clk) disable iff (!rst_n)
        buf_cnt_reg > 3'd1 |-> !c_load)
        else $error("byte buffer reloaded with bytes still waiting");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        c_load && tok_reg.is_end |=> pend_cnt_reg == 3'd0 && !hdr_done_reg)
        else $error("end of block left pending bits or header flag");

    a_token_kept: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && in_data.cmd != CMD_UNUSED |=> a_valid_reg)
        else $error("accepted token lost at input register");
`endif

endmodule
